FILE: hw/rtl/swa_pkg.sv
// shared types and constants for the sliding window arq sender
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps

package swa_pkg;

    localparam int WINDOW_SLOTS_DEF = 3;
    localparam int SEQ_BITS_DEF     = 24;

    localparam int FUNC_BITS      = 2;
    localparam int LABEL_BITS     = 2;
    localparam int TAIL_BITS      = 7;
    localparam int RETRY_BITS     = 5;
    localparam int CFG_INDEX_BITS = 2;
    localparam int QUEUE_DEPTH    = 2;

    localparam logic [RETRY_BITS-1:0] RETRY_RESET = 5'd20;

    // event kinds
    localparam logic [FUNC_BITS-1:0] FUNC_START   = 2'd0;
    localparam logic [FUNC_BITS-1:0] FUNC_ACK     = 2'd1;
    localparam logic [FUNC_BITS-1:0] FUNC_NAK     = 2'd2;
    localparam logic [FUNC_BITS-1:0] FUNC_TIMEOUT = 2'd3;

    // configuration register indexes
    localparam logic [CFG_INDEX_BITS-1:0] CFG_PACKET_COUNT = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_TAIL_LENGTH  = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_RETRY_LIMIT  = 2'd2;

    typedef enum logic [1:0] {
        ST_SENDING = 2'd0,
        ST_DONE    = 2'd1,
        ST_FAILED  = 2'd2
    } t_status;

    typedef enum logic [3:0] {
        PH_IDLE = 4'b0001,
        PH_SEND = 4'b0010,
        PH_LAST = 4'b0100,
        PH_DONE = 4'b1000
    } t_phase;

    // work handed from the event decoder to the transmit sequencer
    typedef struct packed {
        logic    fresh;
        t_status status;
    } t_job;

endpackage

FILE: hw/rtl/swa_queue.sv
// two-entry job queue between the event decoder and the transmit sequencer
// depends on swa_pkg for the job type and depth
`timescale 1ns / 1ps

module swa_queue
    import swa_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    input  logic i_pop,
    output t_job o_job,
    output logic o_valid,
    output logic o_full
);

    localparam int PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CntW = $clog2(QUEUE_DEPTH + 1);

    t_job            r_mem [QUEUE_DEPTH];
    logic [PtrW-1:0] r_wr_ptr;
    logic [PtrW-1:0] r_rd_ptr;
    logic [CntW-1:0] r_count;
    logic [PtrW-1:0] n_wr_ptr;
    logic [PtrW-1:0] n_rd_ptr;
    logic [CntW-1:0] n_count;
    logic            do_push;
    logic            do_pop;

    assign o_valid = (r_count != '0);
    assign o_full  = (r_count == CntW'(QUEUE_DEPTH));
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;
    assign o_job   = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == PtrW'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == PtrW'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        case ({do_push, do_pop})
            2'b10:   n_count = r_count + 1'b1;
            2'b01:   n_count = r_count - 1'b1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

endmodule

FILE: hw/rtl/swa_front.sv
// event decoder: configuration, window state, slot store and slot refill
// depends on swa_pkg; feeds jobs to swa_queue, slot contents to swa_back
`timescale 1ns / 1ps

module swa_front
    import swa_pkg::*;
#(
    parameter int WINDOW_SLOTS = WINDOW_SLOTS_DEF,
    parameter int SEQ_BITS     = SEQ_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_accept,
    input  logic [FUNC_BITS-1:0]            i_func,
    input  logic [LABEL_BITS-1:0]           i_ack_label,
    input  logic signed [SEQ_BITS:0]        i_ack_seq,
    input  logic                            i_cfg_we,
    input  logic [CFG_INDEX_BITS-1:0]       i_cfg_index,
    input  logic [SEQ_BITS-1:0]             i_cfg_data,
    input  logic                            i_q_full,
    output logic                            o_push,
    output t_job                            o_job,
    output logic                            o_busy,
    output logic [LABEL_BITS-1:0]           o_labels [WINDOW_SLOTS],
    output logic [SEQ_BITS:0]               o_words  [WINDOW_SLOTS],
    output logic [$clog2(WINDOW_SLOTS)-1:0] o_head,
    output logic [$clog2(WINDOW_SLOTS)-1:0] o_tail
);

    localparam int SlotW = $clog2(WINDOW_SLOTS);
    localparam int CntW  = $clog2(WINDOW_SLOTS + 1);
    localparam int WordW = SEQ_BITS + 1;

    typedef enum logic [3:0] {
        F_IDLE   = 4'b0001,
        F_DECODE = 4'b0010,
        F_LOAD   = 4'b0100,
        F_FINISH = 4'b1000
    } t_fstate;

    // configuration
    logic [SEQ_BITS-1:0]   r_packet_count;
    logic [TAIL_BITS-1:0]  r_tail_length;
    logic [RETRY_BITS-1:0] r_retry_limit;

    // latched event
    logic [FUNC_BITS-1:0]  r_func;
    logic [LABEL_BITS-1:0] r_label;
    logic [WordW-1:0]      r_seq;

    // slot store, no reset
    logic [LABEL_BITS-1:0] r_labels [WINDOW_SLOTS];
    logic [WordW-1:0]      r_words  [WINDOW_SLOTS];

    t_fstate               r_state,  n_state;
    t_phase                r_phase,  n_phase;
    logic [SlotW-1:0]      r_head,   n_head;
    logic [SlotW-1:0]      r_tail,   n_tail;
    logic [SlotW-1:0]      r_newest, n_newest;
    logic [SEQ_BITS-1:0]   r_loaded, n_loaded;
    logic [LABEL_BITS-1:0] r_next_label, n_next_label;
    logic [RETRY_BITS-1:0] r_retries, n_retries;
    logic [SlotW-1:0]      r_idx,    n_idx;
    logic [CntW-1:0]       r_cnt,    n_cnt;
    logic [SlotW-1:0]      r_k,      n_k;
    logic [SlotW-1:0]      r_first,  n_first;
    logic [SlotW-1:0]      r_latest, n_latest;
    logic                  r_any,    n_any;
    logic                  r_restart, n_restart;

    logic [SEQ_BITS-1:0]   eff_count;
    logic                  remaining;
    logic [SEQ_BITS-1:0]   loaded_inc;
    logic [WordW-1:0]      load_word;
    logic                  load_en;
    logic [WINDOW_SLOTS-1:0] hit;
    logic                  match_valid;
    logic [SlotW-1:0]      match_k;
    logic [SlotW-1:0]      after_newest;
    logic [SlotW-1:0]      idx_next;

    function automatic logic [SlotW-1:0] slot_next(input logic [SlotW-1:0] s);
        slot_next = (s == SlotW'(WINDOW_SLOTS - 1)) ? '0 : s + 1'b1;
    endfunction

    // a packet count of zero behaves as a single packet
    assign eff_count  = (r_packet_count == '0) ? SEQ_BITS'(1) : r_packet_count;
    assign remaining  = (r_loaded < eff_count);
    assign loaded_inc = r_loaded + 1'b1;
    // the final packet carries minus the tail length
    assign load_word  = (loaded_inc == eff_count)
                        ? (WordW'(0) - WordW'(r_tail_length))
                        : {1'b0, loaded_inc};
    assign after_newest = slot_next(r_newest);
    assign idx_next     = slot_next(r_idx);

    always_comb begin
        for (int i = 0; i < WINDOW_SLOTS; i++) begin
            hit[i] = (r_labels[i] == r_label) && (r_words[i] == r_seq);
        end
    end

    // lowest matching slot wins
    always_comb begin
        match_k = '0;
        for (int i = WINDOW_SLOTS - 1; i >= 0; i--) begin
            if (hit[i]) begin
                match_k = SlotW'(i);
            end
        end
    end
    assign match_valid = |hit;

    always_comb begin
        n_state      = r_state;
        n_phase      = r_phase;
        n_head       = r_head;
        n_tail       = r_tail;
        n_newest     = r_newest;
        n_loaded     = r_loaded;
        n_next_label = r_next_label;
        n_retries    = r_retries;
        n_idx        = r_idx;
        n_cnt        = r_cnt;
        n_k          = r_k;
        n_first      = r_first;
        n_latest     = r_latest;
        n_any        = r_any;
        n_restart    = r_restart;
        load_en      = 1'b0;
        o_push       = 1'b0;
        o_job        = '{fresh: 1'b0, status: ST_SENDING};
        case (r_state)
            F_IDLE: begin
                if (i_accept) begin
                    n_state = F_DECODE;
                end
            end
            F_DECODE: begin
                if (!i_q_full) begin
                    n_state = F_IDLE;
                    if (r_func == FUNC_START) begin
                        n_loaded     = '0;
                        n_next_label = '0;
                        n_head       = '0;
                        n_idx        = '0;
                        n_cnt        = '0;
                        n_restart    = 1'b1;
                        n_state      = F_LOAD;
                    end else if (r_phase != PH_SEND && r_phase != PH_LAST) begin
                        n_state = F_IDLE;
                    end else if (r_func == FUNC_TIMEOUT) begin
                        o_push = 1'b1;
                        if (r_phase == PH_LAST && r_retries <= RETRY_BITS'(1)) begin
                            n_phase = PH_DONE;
                            o_job   = '{fresh: 1'b0, status: ST_FAILED};
                        end else begin
                            if (r_phase == PH_LAST) begin
                                n_retries = r_retries - 1'b1;
                            end
                        end
                    end else if (match_valid) begin
                        if (r_func == FUNC_NAK) begin
                            n_head = match_k;
                            n_tail = r_newest;
                        end else if (r_phase == PH_SEND) begin
                            n_restart = 1'b0;
                            n_any     = 1'b0;
                            n_k       = match_k;
                            n_first   = after_newest;
                            n_idx     = after_newest;
                            n_state   = F_LOAD;
                        end else if (match_k == r_newest) begin
                            o_push  = 1'b1;
                            o_job   = '{fresh: 1'b0, status: ST_DONE};
                            n_phase = PH_DONE;
                        end else begin
                            n_tail = match_k;
                        end
                    end
                end
            end
            F_LOAD: begin
                // one slot refilled per cycle
                if (r_restart) begin
                    if (r_cnt != CntW'(WINDOW_SLOTS) && remaining) begin
                        load_en  = 1'b1;
                        n_latest = r_idx;
                        n_idx    = idx_next;
                        n_cnt    = r_cnt + 1'b1;
                    end else begin
                        n_state = F_FINISH;
                    end
                end else begin
                    if (remaining) begin
                        load_en  = 1'b1;
                        n_latest = r_idx;
                        n_any    = 1'b1;
                        if (r_idx == r_k) begin
                            n_state = F_FINISH;
                        end else begin
                            n_idx = idx_next;
                        end
                    end else begin
                        n_state = F_FINISH;
                    end
                end
                if (load_en) begin
                    n_loaded     = loaded_inc;
                    n_next_label = r_next_label + 1'b1;
                end
            end
            F_FINISH: begin
                if (!i_q_full) begin
                    n_state = F_IDLE;
                    if (!remaining) begin
                        n_phase   = PH_LAST;
                        n_retries = r_retry_limit;
                    end
                    if (r_restart) begin
                        n_tail    = r_latest;
                        n_newest  = r_latest;
                        n_retries = r_retry_limit;
                        if (remaining) begin
                            n_phase = PH_SEND;
                        end
                        o_push = 1'b1;
                        o_job  = '{fresh: 1'b1, status: ST_SENDING};
                    end else if (r_any) begin
                        n_head   = r_first;
                        n_tail   = r_latest;
                        n_newest = r_latest;
                        o_push   = 1'b1;
                        o_job    = '{fresh: 1'b1, status: ST_SENDING};
                    end
                end
            end
            default: begin
                n_state = F_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= F_IDLE;
            r_phase      <= PH_IDLE;
            r_head       <= '0;
            r_tail       <= '0;
            r_newest     <= '0;
            r_loaded     <= '0;
            r_next_label <= '0;
            r_retries    <= RETRY_RESET;
            r_idx        <= '0;
            r_cnt        <= '0;
            r_k          <= '0;
            r_first      <= '0;
            r_latest     <= '0;
            r_any        <= 1'b0;
            r_restart    <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_phase      <= n_phase;
            r_head       <= n_head;
            r_tail       <= n_tail;
            r_newest     <= n_newest;
            r_loaded     <= n_loaded;
            r_next_label <= n_next_label;
            r_retries    <= n_retries;
            r_idx        <= n_idx;
            r_cnt        <= n_cnt;
            r_k          <= n_k;
            r_first      <= n_first;
            r_latest     <= n_latest;
            r_any        <= n_any;
            r_restart    <= n_restart;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_packet_count <= SEQ_BITS'(1);
            r_tail_length  <= '0;
            r_retry_limit  <= RETRY_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_PACKET_COUNT: r_packet_count <= i_cfg_data;
                CFG_TAIL_LENGTH:  r_tail_length  <= i_cfg_data[TAIL_BITS-1:0];
                CFG_RETRY_LIMIT:  r_retry_limit  <= i_cfg_data[RETRY_BITS-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_func  <= i_func;
            r_label <= i_ack_label;
            r_seq   <= i_ack_seq;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_en) begin
            r_words[r_idx]  <= load_word;
            r_labels[r_idx] <= r_next_label;
        end
    end

    assign o_busy   = (r_state != F_IDLE);
    assign o_labels = r_labels;
    assign o_words  = r_words;
    assign o_head   = r_head;
    assign o_tail   = r_tail;

endmodule

FILE: hw/rtl/swa_back.sv
// transmit sequencer: walks the window from head to tail, one slot per cycle
// depends on swa_pkg; takes jobs from swa_queue and slot contents from swa_front
`timescale 1ns / 1ps

module swa_back
    import swa_pkg::*;
#(
    parameter int WINDOW_SLOTS = WINDOW_SLOTS_DEF,
    parameter int SEQ_BITS     = SEQ_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_q_valid,
    input  t_job                            i_job,
    output logic                            o_pop,
    input  logic [LABEL_BITS-1:0]           i_labels [WINDOW_SLOTS],
    input  logic [SEQ_BITS:0]               i_words  [WINDOW_SLOTS],
    input  logic [$clog2(WINDOW_SLOTS)-1:0] i_head,
    input  logic [$clog2(WINDOW_SLOTS)-1:0] i_tail,
    output logic                            o_active,
    output logic                            o_strobe,
    output logic [$clog2(WINDOW_SLOTS)-1:0] o_slot,
    output logic signed [SEQ_BITS:0]        o_frame_seq,
    output logic [LABEL_BITS-1:0]           o_frame_label,
    output logic                            o_fresh,
    output logic [1:0]                      o_status,
    output logic                            o_last
);

    localparam int SlotW = $clog2(WINDOW_SLOTS);

    logic             r_active;
    t_job             r_job;
    logic [SlotW-1:0] r_idx;
    logic             is_report;
    logic             at_tail;

    assign o_pop     = !r_active && i_q_valid;
    assign is_report = (r_job.status != ST_SENDING);
    assign at_tail   = (r_idx == i_tail);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
        end else if (o_pop) begin
            r_active <= 1'b1;
        end else if (r_active && (is_report || at_tail)) begin
            r_active <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_job <= i_job;
            r_idx <= i_head;
        end else if (r_active) begin
            r_idx <= (r_idx == SlotW'(WINDOW_SLOTS - 1)) ? '0 : r_idx + 1'b1;
        end
    end

    // status items carry zeroed slot fields
    assign o_active      = r_active;
    assign o_strobe      = r_active;
    assign o_slot        = is_report ? '0 : r_idx;
    assign o_frame_seq   = is_report ? '0 : i_words[r_idx];
    assign o_frame_label = is_report ? '0 : i_labels[r_idx];
    assign o_fresh       = is_report ? 1'b0 : r_job.fresh;
    assign o_status      = r_job.status;
    assign o_last        = is_report || at_tail;

endmodule

FILE: hw/rtl/sliding_window_arq_sender_core.sv
// top level of the go-back-n window controller: decoder, job queue, sequencer
// depends on swa_pkg, swa_front, swa_queue and swa_back
//
// channel   handshake              payload
// event     i_start / o_busy       i_func, i_ack_label, i_ack_seq
// result    o_strobe (no stall)    o_slot, o_frame_seq, o_frame_label,
//                                  o_fresh, o_status, o_last
// config    i_cfg_we               i_cfg_index, i_cfg_data
//
// an item is taken when i_start is high and o_busy low; o_busy stays high
// until every result of that item has been shown
// each item passes accept and decode; start and a sliding ack then refill slots
// (one slot refill per cycle); the job then goes through the queue and gives
// one result per slot (up to WINDOW_SLOTS); ignored events end after decode
// i_rst_n is synchronous and active low; slot contents are not reset
// results are strobed for one cycle each and cannot be held off
`timescale 1ns / 1ps

module sliding_window_arq_sender_core
    import swa_pkg::*;
#(
    parameter int WINDOW_SLOTS = WINDOW_SLOTS_DEF,
    parameter int SEQ_BITS     = SEQ_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    output logic                            o_busy,
    input  logic [FUNC_BITS-1:0]            i_func,
    input  logic [LABEL_BITS-1:0]           i_ack_label,
    input  logic signed [SEQ_BITS:0]        i_ack_seq,
    input  logic                            i_cfg_we,
    input  logic [CFG_INDEX_BITS-1:0]       i_cfg_index,
    input  logic [SEQ_BITS-1:0]             i_cfg_data,
    output logic                            o_strobe,
    output logic [$clog2(WINDOW_SLOTS)-1:0] o_slot,
    output logic signed [SEQ_BITS:0]        o_frame_seq,
    output logic [LABEL_BITS-1:0]           o_frame_label,
    output logic                            o_fresh,
    output logic [1:0]                      o_status,
    output logic                            o_last
);

    localparam int SlotW = $clog2(WINDOW_SLOTS);

    logic                  accept;
    logic                  front_busy;
    logic                  back_active;
    logic                  q_push;
    logic                  q_pop;
    logic                  q_valid;
    logic                  q_full;
    t_job                  push_job;
    t_job                  head_job;
    logic [LABEL_BITS-1:0] slot_labels [WINDOW_SLOTS];
    logic [SEQ_BITS:0]     slot_words  [WINDOW_SLOTS];
    logic [SlotW-1:0]      win_head;
    logic [SlotW-1:0]      win_tail;

    assign o_busy = front_busy || q_valid || back_active;
    assign accept = i_start && !o_busy;

    swa_front #(
        .WINDOW_SLOTS (WINDOW_SLOTS),
        .SEQ_BITS     (SEQ_BITS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_func      (i_func),
        .i_ack_label (i_ack_label),
        .i_ack_seq   (i_ack_seq),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_q_full    (q_full),
        .o_push      (q_push),
        .o_job       (push_job),
        .o_busy      (front_busy),
        .o_labels    (slot_labels),
        .o_words     (slot_words),
        .o_head      (win_head),
        .o_tail      (win_tail)
    );

    swa_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_job   (push_job),
        .i_pop   (q_pop),
        .o_job   (head_job),
        .o_valid (q_valid),
        .o_full  (q_full)
    );

    swa_back #(
        .WINDOW_SLOTS (WINDOW_SLOTS),
        .SEQ_BITS     (SEQ_BITS)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_valid     (q_valid),
        .i_job         (head_job),
        .o_pop         (q_pop),
        .i_labels      (slot_labels),
        .i_words       (slot_words),
        .i_head        (win_head),
        .i_tail        (win_tail),
        .o_active      (back_active),
        .o_strobe      (o_strobe),
        .o_slot        (o_slot),
        .o_frame_seq   (o_frame_seq),
        .o_frame_label (o_frame_label),
        .o_fresh       (o_fresh),
        .o_status      (o_status),
        .o_last        (o_last)
    );

endmodule
